// ----- design/rtcb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtcb_pkg
// types, codes and helpers shared by the three-wire rtc burst master
// ----------------------------------------------------------------------------
package rtcb_pkg;

  localparam int unsigned NUM_CFG = 8;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_W = 8;
  localparam int unsigned NUM_RD = 7;

  typedef logic [CFG_W-1:0] cfg_byte_t;
  typedef cfg_byte_t [NUM_CFG-1:0] cfg_bank_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SECONDS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MINUTES = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOURS   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DAY     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MONTH   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WEEKDAY = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_YEAR    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL = 4'd7;

  localparam cfg_bank_t CFG_RESET = {8'h20, 8'h18, 8'h07, 8'h01,
                                     8'h21, 8'h00, 8'h00, 8'h00};

  // transfer codes
  localparam logic [1:0] OP_CLEAR_WP = 2'd0;
  localparam logic [1:0] OP_WRITE    = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;
  localparam logic [1:0] OP_INVALID  = 2'd3;

  // command bytes and masks
  localparam logic [7:0] CMD_CLEAR_WP = 8'h8e;
  localparam logic [7:0] CMD_WRITE    = 8'hbe;
  localparam logic [7:0] CMD_READ     = 8'hbf;
  localparam logic [7:0] TENS_MASK_7  = 8'h70;
  localparam logic [7:0] TENS_MASK_3  = 8'h30;
  localparam logic [7:0] TENS_MASK_1  = 8'h10;
  localparam logic [7:0] TENS_MASK_F  = 8'hf0;

  typedef struct packed {
    logic       start_req;
    logic [1:0] op;
    logic       io_in;
  } rtcb_item_t;

  typedef struct packed {
    logic       sclk;
    logic       chip_enable;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic       done_res;
    logic [6:0] seconds;
    logic [6:0] minutes;
    logic [6:0] hours;
    logic [5:0] day;
    logic [4:0] month;
    logic [7:0] year;
  } rtcb_res_t;

  function automatic logic [3:0] byte_count(input logic [1:0] op);
    logic [3:0] n;
    case (op)
      OP_CLEAR_WP: n = 4'd2;
      OP_WRITE:    n = 4'd9;
      default:     n = 4'd8;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b, input logic [7:0] tens_mask);
    logic [7:0] masked;
    logic [3:0] tens;
    masked = b & tens_mask;
    tens = masked[7:4];
    return {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0} + {4'b0000, b[3:0]};
  endfunction

endpackage
`default_nettype wire

// ----- design/rtcb_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtcb_cfg
// bank of eight time bytes sent in a burst write
// ----------------------------------------------------------------------------
module rtcb_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [rtcb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rtcb_pkg::CFG_W-1:0]           cfg_data,
  output rtcb_pkg::cfg_bank_t                  bank
);
  import rtcb_pkg::*;

  cfg_bank_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= CFG_RESET;
    end else if (cfg_we && !cfg_index[CFG_IDX_W-1]) begin
      regs[cfg_index[CFG_IDX_W-2:0]] <= cfg_data;
    end
  end

  assign bank = regs;

endmodule
`default_nettype wire

// ----- design/rtcb_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtcb_seq
// bit sequencer: pin levels per tick, read shifting and bcd decode
// ----------------------------------------------------------------------------
module rtcb_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  rtcb_pkg::rtcb_item_t  item,
  input  rtcb_pkg::cfg_bank_t   cfg,
  output rtcb_pkg::rtcb_res_t   res
);
  import rtcb_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_FIN  = 2'd2;

  logic [1:0] phase, phase_next;
  logic [1:0] held_op, held_op_next;
  logic [3:0] byte_index, byte_index_next;
  logic [2:0] bit_index, bit_index_next;
  logic       clock_half, clock_half_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] rd_bytes [0:NUM_RD-1];
  logic [6:0] sec_reg, sec_reg_next;
  logic [6:0] min_reg, min_reg_next;
  logic [6:0] hour_reg, hour_reg_next;
  logic [5:0] day_reg, day_reg_next;
  logic [4:0] month_reg, month_reg_next;
  logic [7:0] year_reg, year_reg_next;

  logic       run_active;
  logic [1:0] run_op;
  logic [3:0] run_byte;
  logic [2:0] run_bit;
  logic       run_half;
  logic [7:0] run_shift;
  logic       reading;
  logic [7:0] wbyte;
  logic [2:0] cfg_sel;
  logic [2:0] rd_idx;
  logic [3:0] byte_inc;
  logic       rd_we;
  logic [7:0] dec_sec, dec_min, dec_hour, dec_day, dec_month, dec_year;

  assign dec_sec   = bcd_to_bin(rd_bytes[0], TENS_MASK_7);
  assign dec_min   = bcd_to_bin(rd_bytes[1], TENS_MASK_7);
  assign dec_hour  = bcd_to_bin(rd_bytes[2], TENS_MASK_7);
  assign dec_day   = bcd_to_bin(rd_bytes[3], TENS_MASK_3);
  assign dec_month = bcd_to_bin(rd_bytes[4], TENS_MASK_1);
  assign dec_year  = bcd_to_bin(rd_bytes[6], TENS_MASK_F);

  assign cfg_sel  = run_byte[2:0] - 3'd1;
  assign rd_idx   = run_byte[2:0] - 3'd1;
  assign byte_inc = run_byte + 4'd1;

  always_comb begin
    case (run_op)
      OP_CLEAR_WP: wbyte = (run_byte == 4'd0) ? CMD_CLEAR_WP : 8'h00;
      OP_WRITE:    wbyte = (run_byte == 4'd0) ? CMD_WRITE : cfg[cfg_sel];
      default:     wbyte = CMD_READ;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    held_op_next    = held_op;
    byte_index_next = byte_index;
    bit_index_next  = bit_index;
    clock_half_next = clock_half;
    shift_reg_next  = shift_reg;
    sec_reg_next    = sec_reg;
    min_reg_next    = min_reg;
    hour_reg_next   = hour_reg;
    day_reg_next    = day_reg;
    month_reg_next  = month_reg;
    year_reg_next   = year_reg;
    run_active      = 1'b0;
    run_op          = held_op;
    run_byte        = byte_index;
    run_bit         = bit_index;
    run_half        = clock_half;
    run_shift       = shift_reg;
    reading         = 1'b0;
    rd_we           = 1'b0;
    res             = '0;

    unique case (phase)
      PH_FIN: begin
        res.done_res = 1'b1;
        phase_next = PH_IDLE;
        if (held_op == OP_READ) begin
          sec_reg_next   = dec_sec[6:0];
          min_reg_next   = dec_min[6:0];
          hour_reg_next  = dec_hour[6:0];
          day_reg_next   = dec_day[5:0];
          month_reg_next = dec_month[4:0];
          year_reg_next  = dec_year;
        end
      end
      PH_RUN: begin
        run_active = 1'b1;
      end
      default: begin
        phase_next = PH_IDLE;
        if (item.start_req && item.op != OP_INVALID) begin
          run_active = 1'b1;
          run_op     = item.op;
          run_byte   = 4'd0;
          run_bit    = 3'd0;
          run_half   = 1'b0;
          run_shift  = 8'h00;
        end
      end
    endcase

    if (run_active) begin
      phase_next       = PH_RUN;
      held_op_next     = run_op;
      byte_index_next  = run_byte;
      bit_index_next   = run_bit;
      shift_reg_next   = run_shift;
      res.chip_enable  = 1'b1;
      res.busy_res     = 1'b1;
      res.sclk         = run_half;
      reading = (run_op == OP_READ) && (run_byte != 4'd0);
      if (reading) begin
        if (!run_half) begin
          shift_reg_next = {item.io_in, run_shift[7:1]};
          if (run_bit == 3'd7 && run_byte <= 4'd7) begin
            rd_we = 1'b1;
          end
        end
      end else begin
        res.io_drive = 1'b1;
        res.io_out   = wbyte[run_bit];
      end
      if (!run_half) begin
        clock_half_next = 1'b1;
      end else begin
        clock_half_next = 1'b0;
        if (run_bit == 3'd7) begin
          bit_index_next  = 3'd0;
          byte_index_next = byte_inc;
          if (byte_inc >= byte_count(run_op)) begin
            phase_next = PH_FIN;
          end
        end else begin
          bit_index_next = run_bit + 3'd1;
        end
      end
    end

    res.seconds = sec_reg_next;
    res.minutes = min_reg_next;
    res.hours   = hour_reg_next;
    res.day     = day_reg_next;
    res.month   = month_reg_next;
    res.year    = year_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_op    <= OP_CLEAR_WP;
      byte_index <= 4'd0;
      bit_index  <= 3'd0;
      clock_half <= 1'b0;
      shift_reg  <= 8'h00;
      sec_reg    <= '0;
      min_reg    <= '0;
      hour_reg   <= '0;
      day_reg    <= '0;
      month_reg  <= '0;
      year_reg   <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      held_op    <= held_op_next;
      byte_index <= byte_index_next;
      bit_index  <= bit_index_next;
      clock_half <= clock_half_next;
      shift_reg  <= shift_reg_next;
      sec_reg    <= sec_reg_next;
      min_reg    <= min_reg_next;
      hour_reg   <= hour_reg_next;
      day_reg    <= day_reg_next;
      month_reg  <= month_reg_next;
      year_reg   <= year_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && rd_we) begin
      rd_bytes[rd_idx] <= shift_reg_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/rtc_three_wire_burst_master.sv -----
`default_nettype none
// path: a taken tick passes through the input register, then the result
// register, before its result is offered
// throughput: one tick per cycle, sustained while out_stall stays low
// reset: synchronous rst returns the sequencer to idle, clears the decoded
// time and reloads the time bytes with their defaults
// ----------------------------------------------------------------------------
// rtc_three_wire_burst_master
// three-wire rtc link master, one half-bit tick per item
// ----------------------------------------------------------------------------
module rtc_three_wire_burst_master (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rtcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtcb_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            start_req,
  input  logic [1:0]                      op,
  input  logic                            io_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            sclk,
  output logic                            chip_enable,
  output logic                            io_out,
  output logic                            io_drive,
  output logic                            busy_res,
  output logic                            done_res,
  output logic [6:0]                      seconds,
  output logic [6:0]                      minutes,
  output logic [6:0]                      hours,
  output logic [5:0]                      day,
  output logic [4:0]                      month,
  output logic [7:0]                      year
);
  import rtcb_pkg::*;

  cfg_bank_t  bank;
  rtcb_item_t item;
  logic       item_valid;
  logic       advance;
  logic       in_take;
  rtcb_res_t  res_next;
  rtcb_res_t  res;

  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  rtcb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bank      (bank)
  );

  rtcb_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (bank),
    .res     (res_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= in_take || (item_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.start_req <= start_req;
      item.op        <= op;
      item.io_in     <= io_in;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign sclk        = res.sclk;
  assign chip_enable = res.chip_enable;
  assign io_out      = res.io_out;
  assign io_drive    = res.io_drive;
  assign busy_res    = res.busy_res;
  assign done_res    = res.done_res;
  assign seconds     = res.seconds;
  assign minutes     = res.minutes;
  assign hours       = res.hours;
  assign day         = res.day;
  assign month       = res.month;
  assign year        = res.year;

endmodule
`default_nettype wire
